// File: sv/fbnpm_pkg.sv
// ----------------------------------------------------------------------------
// File block node path mapper: shared package
// Tree geometry constants, derived widths, the zone code and the request,
// response and inter-stage payload types.
// ----------------------------------------------------------------------------
package fbnpm_pkg;

	// Tree geometry.
	localparam int unsigned INODE_DIRECT_SLOTS   = 923;
	localparam int unsigned POINTERS_PER_NODE    = 1018;
	localparam int unsigned XATTR_RESERVED_SLOTS = 50;

	localparam longint unsigned PER_L  = longint'(POINTERS_PER_NODE);
	localparam longint unsigned PER2_L = PER_L * PER_L;
	localparam longint unsigned PER3_L = PER2_L * PER_L;

	// Field widths.
	localparam int IDX_W   = 32;
	localparam int DEPTH_W = 2;
	localparam int SLOT_W  = 10;

	// Widths of the values inside the datapath.
	localparam int Q_W   = $clog2(PER_L);   // one slot inside a node
	localparam int MID_W = $clog2(PER2_L);  // offset inside a second-level subtree
	localparam int R_W   = $clog2(PER3_L);  // offset inside the largest zone

	// Zone that a block index falls into.
	typedef enum logic [2:0] {
		ZONE_INODE,
		ZONE_DNODE1,
		ZONE_DNODE2,
		ZONE_IND1,
		ZONE_IND2,
		ZONE_DIND,
		ZONE_NONE
	} zone_t;

	typedef struct packed {
		logic [IDX_W-1:0] block_index;
		logic             inline_xattr;
	} req_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               out_of_range;
		logic [SLOT_W-1:0]  first_slot;
		logic [SLOT_W-1:0]  second_slot;
		logic [SLOT_W-1:0]  third_slot;
		logic [SLOT_W-1:0]  fourth_slot;
	} rsp_t;

	// Classifier result: zone, first slot and offset within the zone.
	typedef struct packed {
		zone_t             zone;
		logic [SLOT_W-1:0] first_slot;
		logic [R_W-1:0]    r;
	} cls_t;

	// After the division by the square of the node size.
	typedef struct packed {
		zone_t             zone;
		logic [SLOT_W-1:0] first_slot;
		logic [Q_W-1:0]    q1;
		logic [MID_W-1:0]  mid;
	} dv1_t;

	// After the division by the node size.
	typedef struct packed {
		zone_t             zone;
		logic [SLOT_W-1:0] first_slot;
		logic [Q_W-1:0]    q1;
		logic [Q_W-1:0]    q2;
		logic [Q_W-1:0]    rem;
	} dv2_t;

endpackage

// File: sv/file_block_node_path_mapper.sv
// ----------------------------------------------------------------------------
// File block node path mapper
// Maps a logical file block number onto its path through a multilevel inode
// pointer tree: depth, the inode or node id slot, and the slot per level.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   request | req_valid, req_stall | req: block_index, inline_xattr
//   result  | rsp_valid, rsp_stall | rsp: depth, out_of_range, four slots
//
// A new request is taken every cycle while req_stall is low. The nine register stages
// are the zone compare, the zone base subtraction, three stages of the divider by the
// squared node size, three of the divider by the node size, and the output register.
// Reset clears only the stage valid bits. Each stage holds its item while the stage
// after it is full and stalled; empty stages keep filling, so req_stall rises only
// once every stage holds a request.
//
module file_block_node_path_mapper
	import fbnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic cls_valid;
	logic cls_stall;
	cls_t cls_data;
	logic dv1_valid;
	logic dv1_stall;
	dv1_t dv1_data;
	logic dv2_valid;
	logic dv2_stall;
	dv2_t dv2_data;
	logic v_s9;
	logic ld_s9;
	rsp_t rsp_s9;
	rsp_t rsp_in;

	// Zone compare and offset inside the zone.
	fbnpm_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req_valid),
		.up_stall (req_stall),
		.up_data  (req),
		.dn_valid (cls_valid),
		.dn_stall (cls_stall),
		.dn_data  (cls_data)
	);

	// The offset splits into the slot of the first child node and the rest.
	fbnpm_div_sq u_div_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cls_valid),
		.up_stall (cls_stall),
		.up_data  (cls_data),
		.dn_valid (dv1_valid),
		.dn_stall (dv1_stall),
		.dn_data  (dv1_data)
	);

	// The rest splits into the slots of the two lower levels.
	fbnpm_div_node u_div_node (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dv1_valid),
		.up_stall (dv1_stall),
		.up_data  (dv1_data),
		.dn_valid (dv2_valid),
		.dn_stall (dv2_stall),
		.dn_data  (dv2_data)
	);

	assign ld_s9     = !v_s9 || !rsp_stall;
	assign dv2_stall = !ld_s9;

	// Place the quotients by depth. Shallower zones pass through the dividers
	// with leading quotients of zero, so the low slots line up naturally.
	always_comb begin
		rsp_in              = '0;
		rsp_in.first_slot   = dv2_data.first_slot;
		case (dv2_data.zone)
			ZONE_INODE: begin
				rsp_in.depth = DEPTH_W'(0);
			end
			ZONE_DNODE1, ZONE_DNODE2: begin
				rsp_in.depth       = DEPTH_W'(1);
				rsp_in.second_slot = SLOT_W'(dv2_data.rem);
			end
			ZONE_IND1, ZONE_IND2: begin
				rsp_in.depth       = DEPTH_W'(2);
				rsp_in.second_slot = SLOT_W'(dv2_data.q2);
				rsp_in.third_slot  = SLOT_W'(dv2_data.rem);
			end
			ZONE_DIND: begin
				rsp_in.depth       = DEPTH_W'(3);
				rsp_in.second_slot = SLOT_W'(dv2_data.q1);
				rsp_in.third_slot  = SLOT_W'(dv2_data.q2);
				rsp_in.fourth_slot = SLOT_W'(dv2_data.rem);
			end
			default: begin
				// Beyond the tree: only the flag is set.
				rsp_in.first_slot   = '0;
				rsp_in.out_of_range = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (ld_s9) begin
			v_s9 <= dv2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s9 && dv2_valid) begin
			rsp_s9 <= rsp_in;
		end
	end

	assign rsp_valid = v_s9;
	assign rsp       = rsp_s9;

`ifndef ASSERT_OFF
	// Backpressure reaches the request side only when the result is held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled while the result side is free");

	// An out-of-range result carries no path.
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_of_range) |->
		(rsp.depth == '0 && rsp.first_slot == '0 && rsp.second_slot == '0 &&
		 rsp.third_slot == '0 && rsp.fourth_slot == '0))
		else $error("out-of-range result with nonzero fields");

	// Slots below the depth read zero.
	a_direct_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.depth == DEPTH_W'(0)) |->
		(rsp.second_slot == '0 && rsp.third_slot == '0 && rsp.fourth_slot == '0))
		else $error("direct result with child slots");

	a_lower_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.depth != DEPTH_W'(3)) |-> (rsp.fourth_slot == '0))
		else $error("fourth slot set below the double-indirect depth");

	// The dividers keep every slot below the node size.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.second_slot < SLOT_W'(PER_L) &&
		rsp.third_slot < SLOT_W'(PER_L) && rsp.fourth_slot < SLOT_W'(PER_L)))
		else $error("slot beyond the node size");
`endif

endmodule

// File: sv/fbnpm_classify.sv
// ----------------------------------------------------------------------------
// File block node path mapper: zone classifier
// Two stages: compare the index against the zone bounds, then subtract the
// zone base to get the offset inside the zone.
// ----------------------------------------------------------------------------
module fbnpm_classify
	import fbnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  req_t up_data,
	output logic dn_valid,
	input  logic dn_stall,
	output cls_t dn_data
);

	localparam int CMP_W = 34;

	localparam logic [CMP_W-1:0] DIR_FULL = CMP_W'(INODE_DIRECT_SLOTS);
	localparam logic [CMP_W-1:0] DIR_XA   =
		CMP_W'(INODE_DIRECT_SLOTS - XATTR_RESERVED_SLOTS);

	// Zone starts relative to the end of the direct area.
	localparam logic [CMP_W-1:0] OFS_DN2 = CMP_W'(PER_L);
	localparam logic [CMP_W-1:0] OFS_IN1 = CMP_W'(2 * PER_L);
	localparam logic [CMP_W-1:0] OFS_IN2 = CMP_W'(2 * PER_L + PER2_L);
	localparam logic [CMP_W-1:0] OFS_DIN = CMP_W'(2 * PER_L + 2 * PER2_L);
	localparam logic [CMP_W-1:0] OFS_END = CMP_W'(2 * PER_L + 2 * PER2_L + PER3_L);

	logic             v_s1;
	zone_t            zone_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             xa_s1;
	logic             v_s2;
	cls_t             cls_s2;
	logic             ld_s1;
	logic             ld_s2;
	logic [CMP_W-1:0] dir_in;
	logic [CMP_W-1:0] idx_in;
	zone_t            zone_in;
	logic [CMP_W-1:0] dir_s1;
	logic [CMP_W-1:0] base_s1;
	logic [CMP_W-1:0] diff_s1;
	cls_t             cls_in;

	assign ld_s2    = !v_s2 || !dn_stall;
	assign ld_s1    = !v_s1 || ld_s2;
	assign up_stall = !ld_s1;

	// Stage 1: zone compare.
	always_comb begin
		dir_in = up_data.inline_xattr ? DIR_XA : DIR_FULL;
		idx_in = CMP_W'(up_data.block_index);
		if (idx_in < dir_in) begin
			zone_in = ZONE_INODE;
		end else if (idx_in < dir_in + OFS_DN2) begin
			zone_in = ZONE_DNODE1;
		end else if (idx_in < dir_in + OFS_IN1) begin
			zone_in = ZONE_DNODE2;
		end else if (idx_in < dir_in + OFS_IN2) begin
			zone_in = ZONE_IND1;
		end else if (idx_in < dir_in + OFS_DIN) begin
			zone_in = ZONE_IND2;
		end else if (idx_in < dir_in + OFS_END) begin
			zone_in = ZONE_DIND;
		end else begin
			zone_in = ZONE_NONE;
		end
	end

	// Stage 2: offset inside the zone and the first slot.
	always_comb begin
		dir_s1 = xa_s1 ? DIR_XA : DIR_FULL;
		case (zone_s1)
			ZONE_DNODE1: base_s1 = dir_s1;
			ZONE_DNODE2: base_s1 = dir_s1 + OFS_DN2;
			ZONE_IND1:   base_s1 = dir_s1 + OFS_IN1;
			ZONE_IND2:   base_s1 = dir_s1 + OFS_IN2;
			ZONE_DIND:   base_s1 = dir_s1 + OFS_DIN;
			default:     base_s1 = '0;
		endcase
		diff_s1 = CMP_W'(idx_s1) - base_s1;

		cls_in.zone = zone_s1;
		cls_in.r    = diff_s1[R_W-1:0];
		case (zone_s1)
			ZONE_INODE: begin
				cls_in.first_slot = idx_s1[SLOT_W-1:0];
				cls_in.r          = '0;
			end
			ZONE_DNODE1: cls_in.first_slot = SLOT_W'(INODE_DIRECT_SLOTS + 1);
			ZONE_DNODE2: cls_in.first_slot = SLOT_W'(INODE_DIRECT_SLOTS + 2);
			ZONE_IND1:   cls_in.first_slot = SLOT_W'(INODE_DIRECT_SLOTS + 3);
			ZONE_IND2:   cls_in.first_slot = SLOT_W'(INODE_DIRECT_SLOTS + 4);
			ZONE_DIND:   cls_in.first_slot = SLOT_W'(INODE_DIRECT_SLOTS + 5);
			default: begin
				cls_in.first_slot = '0;
				cls_in.r          = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= up_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && up_valid) begin
			zone_s1 <= zone_in;
			idx_s1  <= up_data.block_index;
			xa_s1   <= up_data.inline_xattr;
		end
		if (ld_s2 && v_s1) begin
			cls_s2 <= cls_in;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = cls_s2;

endmodule

// File: sv/fbnpm_div_sq.sv
// ----------------------------------------------------------------------------
// File block node path mapper: divider by the squared node size
// Three stages: reciprocal multiply, back multiply, remainder correction.
// ----------------------------------------------------------------------------
module fbnpm_div_sq
	import fbnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  cls_t up_data,
	output logic dn_valid,
	input  logic dn_stall,
	output dv1_t dn_data
);

	// The estimate floor(x * RECIP / 2^R_W) is the quotient or one below it.
	localparam longint unsigned RECIP = (64'd1 << R_W) / PER2_L;
	localparam int RC_W = $clog2(RECIP + 1);
	localparam int P_W  = R_W + RC_W;

	logic              v_s3;
	logic              v_s4;
	logic              v_s5;
	logic              ld_s3;
	logic              ld_s4;
	logic              ld_s5;
	zone_t             zone_s3;
	zone_t             zone_s4;
	logic [SLOT_W-1:0] first_s3;
	logic [SLOT_W-1:0] first_s4;
	logic [R_W-1:0]    x_s3;
	logic [R_W-1:0]    x_s4;
	logic [Q_W-1:0]    qe_s3;
	logic [Q_W-1:0]    qe_s4;
	logic [R_W-1:0]    qd_s4;
	dv1_t              out_s5;
	logic [P_W-1:0]    prod;
	logic [P_W-1:0]    prod_sh;
	logic [R_W-1:0]    rem;
	dv1_t              out_in;

	assign ld_s5    = !v_s5 || !dn_stall;
	assign ld_s4    = !v_s4 || ld_s5;
	assign ld_s3    = !v_s3 || ld_s4;
	assign up_stall = !ld_s3;

	always_comb begin
		prod    = P_W'(up_data.r) * P_W'(RECIP);
		prod_sh = prod >> R_W;
	end

	always_comb begin
		rem            = x_s4 - qd_s4;
		out_in.zone       = zone_s4;
		out_in.first_slot = first_s4;
		if (rem >= R_W'(PER2_L)) begin
			out_in.q1  = qe_s4 + Q_W'(1);
			out_in.mid = MID_W'(rem - R_W'(PER2_L));
		end else begin
			out_in.q1  = qe_s4;
			out_in.mid = rem[MID_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld_s3) begin
				v_s3 <= up_valid;
			end
			if (ld_s4) begin
				v_s4 <= v_s3;
			end
			if (ld_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && up_valid) begin
			zone_s3  <= up_data.zone;
			first_s3 <= up_data.first_slot;
			x_s3     <= up_data.r;
			qe_s3    <= prod_sh[Q_W-1:0];
		end
		if (ld_s4 && v_s3) begin
			zone_s4  <= zone_s3;
			first_s4 <= first_s3;
			x_s4     <= x_s3;
			qe_s4    <= qe_s3;
			qd_s4    <= R_W'(qe_s3) * R_W'(PER2_L);
		end
		if (ld_s5 && v_s4) begin
			out_s5 <= out_in;
		end
	end

	assign dn_valid = v_s5;
	assign dn_data  = out_s5;

endmodule

// File: sv/fbnpm_div_node.sv
// ----------------------------------------------------------------------------
// File block node path mapper: divider by the node size
// Three stages: reciprocal multiply, back multiply, remainder correction.
// ----------------------------------------------------------------------------
module fbnpm_div_node
	import fbnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  dv1_t up_data,
	output logic dn_valid,
	input  logic dn_stall,
	output dv2_t dn_data
);

	// The estimate floor(x * RECIP / 2^MID_W) is the quotient or one below it.
	localparam longint unsigned RECIP = (64'd1 << MID_W) / PER_L;
	localparam int RC_W = $clog2(RECIP + 1);
	localparam int P_W  = MID_W + RC_W;

	logic              v_s6;
	logic              v_s7;
	logic              v_s8;
	logic              ld_s6;
	logic              ld_s7;
	logic              ld_s8;
	zone_t             zone_s6;
	zone_t             zone_s7;
	logic [SLOT_W-1:0] first_s6;
	logic [SLOT_W-1:0] first_s7;
	logic [Q_W-1:0]    q1_s6;
	logic [Q_W-1:0]    q1_s7;
	logic [MID_W-1:0]  x_s6;
	logic [MID_W-1:0]  x_s7;
	logic [Q_W-1:0]    qe_s6;
	logic [Q_W-1:0]    qe_s7;
	logic [MID_W-1:0]  qd_s7;
	dv2_t              out_s8;
	logic [P_W-1:0]    prod;
	logic [P_W-1:0]    prod_sh;
	logic [MID_W-1:0]  rem;
	dv2_t              out_in;

	assign ld_s8    = !v_s8 || !dn_stall;
	assign ld_s7    = !v_s7 || ld_s8;
	assign ld_s6    = !v_s6 || ld_s7;
	assign up_stall = !ld_s6;

	always_comb begin
		prod    = P_W'(up_data.mid) * P_W'(RECIP);
		prod_sh = prod >> MID_W;
	end

	always_comb begin
		rem               = x_s7 - qd_s7;
		out_in.zone       = zone_s7;
		out_in.first_slot = first_s7;
		out_in.q1         = q1_s7;
		if (rem >= MID_W'(PER_L)) begin
			out_in.q2  = qe_s7 + Q_W'(1);
			out_in.rem = Q_W'(rem - MID_W'(PER_L));
		end else begin
			out_in.q2  = qe_s7;
			out_in.rem = rem[Q_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (ld_s6) begin
				v_s6 <= up_valid;
			end
			if (ld_s7) begin
				v_s7 <= v_s6;
			end
			if (ld_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6 && up_valid) begin
			zone_s6  <= up_data.zone;
			first_s6 <= up_data.first_slot;
			q1_s6    <= up_data.q1;
			x_s6     <= up_data.mid;
			qe_s6    <= prod_sh[Q_W-1:0];
		end
		if (ld_s7 && v_s6) begin
			zone_s7  <= zone_s6;
			first_s7 <= first_s6;
			q1_s7    <= q1_s6;
			x_s7     <= x_s6;
			qe_s7    <= qe_s6;
			qd_s7    <= MID_W'(qe_s6) * MID_W'(PER_L);
		end
		if (ld_s8 && v_s7) begin
			out_s8 <= out_in;
		end
	end

	assign dn_valid = v_s8;
	assign dn_data  = out_s8;

endmodule

// File: test/tb_file_block_node_path_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// File block node path mapper: testbench
// Drives block index requests through the valid/stall channel: first a
// directed table of zone edges and out-of-range indexes, then random indexes
// spread over every zone. Random gaps and stalls, a long receiver hold-off
// and a full drain are included. Each result is checked field by field
// against a typed-in path or the pointer tree model kept in this file.
// ----------------------------------------------------------------------------
module tb_file_block_node_path_mapper;
	import fbnpm_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;   // nine-stage pipeline plus margin
	localparam int ZONES        = 7;

	// Zones in the order they are laid out along the file.
	localparam zone_t ZONE_ORDER [ZONES] = '{ZONE_INODE, ZONE_DNODE1, ZONE_DNODE2,
		ZONE_IND1, ZONE_IND2, ZONE_DIND, ZONE_NONE};

	// One row of the directed table. When known is set the expected path is
	// typed in; otherwise it comes from the tree model below.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             xattr;
		logic             known;
		rsp_t             want;
	} dir_row_t;

	localparam rsp_t RSP_OOR = '{2'd0, 1'b1, 10'd0, 10'd0, 10'd0, 10'd0};
	localparam rsp_t RSP_TBD = '0;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// First and last inode pointers, with and without inline attributes.
		'{32'd0,          1'b0, 1'b1, '{2'd0, 1'b0, 10'd0,   10'd0, 10'd0, 10'd0}},
		'{32'd0,          1'b1, 1'b1, '{2'd0, 1'b0, 10'd0,   10'd0, 10'd0, 10'd0}},
		'{32'd922,        1'b0, 1'b1, '{2'd0, 1'b0, 10'd922, 10'd0, 10'd0, 10'd0}},
		'{32'd872,        1'b1, 1'b1, '{2'd0, 1'b0, 10'd872, 10'd0, 10'd0, 10'd0}},
		// Entry into the first direct node for both direct area sizes.
		'{32'd873,        1'b1, 1'b1, '{2'd1, 1'b0, 10'd924, 10'd0, 10'd0, 10'd0}},
		'{32'd923,        1'b0, 1'b1, '{2'd1, 1'b0, 10'd924, 10'd0, 10'd0, 10'd0}},
		'{32'd923,        1'b1, 1'b0, RSP_TBD},
		// Last slot of the first direct node, first of the second.
		'{32'd1940,       1'b0, 1'b0, RSP_TBD},
		'{32'd1941,       1'b0, 1'b1, '{2'd1, 1'b0, 10'd925, 10'd0, 10'd0, 10'd0}},
		// Indirect nodes: first entries and the last slot of the first one.
		'{32'd2959,       1'b0, 1'b1, '{2'd2, 1'b0, 10'd926, 10'd0, 10'd0, 10'd0}},
		'{32'd1039282,    1'b0, 1'b0, RSP_TBD},
		'{32'd1039283,    1'b0, 1'b1, '{2'd2, 1'b0, 10'd927, 10'd0, 10'd0, 10'd0}},
		// Double-indirect node.
		'{32'd2075607,    1'b0, 1'b1, '{2'd3, 1'b0, 10'd928, 10'd0, 10'd0, 10'd0}},
		'{32'd2075606,    1'b1, 1'b0, RSP_TBD},
		'{32'h3EF14A9F,   1'b0, 1'b0, RSP_TBD},
		'{32'h2AAAAAAA,   1'b1, 1'b0, RSP_TBD},
		// Largest mappable block and the one just past it, per direct size.
		'{32'd1057053438, 1'b0, 1'b0, RSP_TBD},
		'{32'd1057053439, 1'b0, 1'b1, RSP_OOR},
		'{32'd1057053388, 1'b1, 1'b0, RSP_TBD},
		'{32'd1057053389, 1'b1, 1'b1, RSP_OOR},
		// Far beyond the tree.
		'{32'h55555555,   1'b0, 1'b1, RSP_OOR},
		'{32'h80000000,   1'b1, 1'b1, RSP_OOR},
		'{32'hFFFFFFFF,   1'b0, 1'b1, RSP_OOR},
		'{32'hFFFFFFFF,   1'b1, 1'b1, RSP_OOR}
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Expected paths in request order, oldest at the front.
	rsp_t path_q [$];

	int err_count = 0;
	int rsp_seen  = 0;

	// Knobs shared between the stimulus sequence and the two channel drivers.
	bit gap_on       = 1'b1;  // sender inserts random idle cycles
	bit stall_on     = 1'b1;  // receiver stalls at random
	bit hold_off_req = 1'b0;  // ask the receiver for one long hold-off

	file_block_node_path_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Tree model
	// ------------------------------------------------------------------------

	// Number of file blocks covered by one zone. The inode area loses the
	// reserved attribute slots when inline attributes are kept.
	function automatic longint unsigned zone_span(input zone_t z, input logic xattr);
		case (z)
			ZONE_INODE: begin
				if (xattr)
					return longint'(INODE_DIRECT_SLOTS - XATTR_RESERVED_SLOTS);
				return longint'(INODE_DIRECT_SLOTS);
			end
			ZONE_DNODE1, ZONE_DNODE2: return PER_L;
			ZONE_IND1, ZONE_IND2:     return PER2_L;
			ZONE_DIND:                return PER3_L;
			default:                  return 0;
		endcase
	endfunction

	// First file block of a zone; for ZONE_NONE this is one past the last
	// mappable block.
	function automatic longint unsigned zone_base(input zone_t z, input logic xattr);
		longint unsigned sum;
		bit hit;
		sum = 0;
		hit = 1'b0;
		for (int k = 0; k < ZONES; k++) begin
			if (ZONE_ORDER[k] == z)
				hit = 1'b1;
			if (!hit)
				sum += zone_span(ZONE_ORDER[k], xattr);
		end
		return sum;
	endfunction

	// Walks the zones in file order, then splits the offset inside the zone
	// into one slot per level of the tree.
	function automatic rsp_t predict_path(input req_t r);
		longint unsigned off;
		zone_t zn;
		rsp_t p;
		off = r.block_index;
		zn  = ZONE_NONE;
		p   = '0;
		for (int k = 0; k < ZONES - 1; k++) begin
			if (zn == ZONE_NONE) begin
				if (off < zone_span(ZONE_ORDER[k], r.inline_xattr))
					zn = ZONE_ORDER[k];
				else
					off -= zone_span(ZONE_ORDER[k], r.inline_xattr);
			end
		end
		case (zn)
			ZONE_INODE: begin
				p.first_slot = SLOT_W'(off);
			end
			ZONE_DNODE1, ZONE_DNODE2: begin
				p.depth       = DEPTH_W'(1);
				p.first_slot  = SLOT_W'(INODE_DIRECT_SLOTS + ((zn == ZONE_DNODE1) ? 1 : 2));
				p.second_slot = SLOT_W'(off);
			end
			ZONE_IND1, ZONE_IND2: begin
				p.depth       = DEPTH_W'(2);
				p.first_slot  = SLOT_W'(INODE_DIRECT_SLOTS + ((zn == ZONE_IND1) ? 3 : 4));
				p.second_slot = SLOT_W'(off / PER_L);
				p.third_slot  = SLOT_W'(off % PER_L);
			end
			ZONE_DIND: begin
				p.depth       = DEPTH_W'(3);
				p.first_slot  = SLOT_W'(INODE_DIRECT_SLOTS + 5);
				p.second_slot = SLOT_W'(off / PER2_L);
				p.third_slot  = SLOT_W'((off / PER_L) % PER_L);
				p.fourth_slot = SLOT_W'(off % PER_L);
			end
			default: begin
				// Past the end of the tree every other field reads zero.
				p.out_of_range = 1'b1;
			end
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Random requests
	// ------------------------------------------------------------------------

	// Each tree zone is picked about equally often, however small it is, so
	// the shallow zones are not drowned out by the double-indirect range.
	// The rest goes past the end, to fully random words, or to the blocks
	// right around a zone boundary.
	function automatic req_t rand_request();
		req_t r;
		longint unsigned lo;
		longint unsigned span;
		int unsigned pick;
		r.inline_xattr = 1'($urandom_range(1));
		pick = $urandom_range(9);
		if (pick <= 5) begin
			lo   = zone_base(ZONE_ORDER[pick], r.inline_xattr);
			span = zone_span(ZONE_ORDER[pick], r.inline_xattr);
			r.block_index = IDX_W'(lo + $urandom_range(32'(span - 1)));
		end else if (pick == 6) begin
			lo = zone_base(ZONE_NONE, r.inline_xattr);
			r.block_index = IDX_W'(lo + $urandom_range(32'(64'hFFFF_FFFF - lo)));
		end else if (pick == 7) begin
			r.block_index = $urandom;
		end else begin
			lo = zone_base(ZONE_ORDER[$urandom_range(1, ZONES - 1)], r.inline_xattr);
			r.block_index = IDX_W'(lo + $urandom_range(2) - 1);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one request and returns at the clock edge where it is taken.
	// The expected path is queued at that same edge. Each call begins where
	// the previous one returned, so the new payload follows the previous request
	// without valid ever dropping unless a gap is wanted.
	task automatic send_request(input req_t r, input rsp_t want);
		if (gap_on && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		path_q.push_back(want);
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Random stalls, plus one long hold-off on request. The hold-off length
	// is counted here so the sender keeps pushing while the pipeline backs up.
	initial begin : rsp_driver
		int hold_cnt;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= stall_on && ($urandom_range(99) < 30);
			end
		end
	end

	task automatic report_mismatch(input string msg);
		if (err_count < 40)
			$display("mismatch at result %0d: %s", rsp_seen, msg);
		err_count++;
	endtask

	// Every accepted result is matched against the oldest queued path.
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (path_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = path_q.pop_front();
				if (rsp.depth !== want.depth)
					report_mismatch($sformatf("depth %0d, expected %0d",
						rsp.depth, want.depth));
				if (rsp.out_of_range !== want.out_of_range)
					report_mismatch($sformatf("out_of_range %0d, expected %0d",
						rsp.out_of_range, want.out_of_range));
				if (rsp.first_slot !== want.first_slot)
					report_mismatch($sformatf("first_slot %0d, expected %0d",
						rsp.first_slot, want.first_slot));
				if (rsp.second_slot !== want.second_slot)
					report_mismatch($sformatf("second_slot %0d, expected %0d",
						rsp.second_slot, want.second_slot));
				if (rsp.third_slot !== want.third_slot)
					report_mismatch($sformatf("third_slot %0d, expected %0d",
						rsp.third_slot, want.third_slot));
				if (rsp.fourth_slot !== want.fourth_slot)
					report_mismatch($sformatf("fourth_slot %0d, expected %0d",
						rsp.fourth_slot, want.fourth_slot));
			end
			rsp_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		req_t r;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: zone edges, both direct area sizes and indexes
		// beyond the tree, with idling on both sides.
		for (int i = 0; i < DIR_ROWS; i++) begin
			r.block_index  = DIR_TAB[i].idx;
			r.inline_xattr = DIR_TAB[i].xattr;
			send_request(r, DIR_TAB[i].known ? DIR_TAB[i].want : predict_path(r));
		end

		// A long stretch at full rate with neither side idling.
		gap_on   = 1'b0;
		stall_on = 1'b0;
		for (int i = 0; i < 300; i++) begin
			r = rand_request();
			send_request(r, predict_path(r));
		end

		// The receiver holds off for a long time while requests keep coming,
		// so every stage fills and the block must push back on its input.
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++) begin
			r = rand_request();
			send_request(r, predict_path(r));
		end

		// The sender goes quiet until the pipeline has drained completely.
		req_valid <= 1'b0;
		while (path_q.size() != 0)
			@(posedge clk);

		// The bulk of the random requests, with idling on both sides.
		gap_on   = 1'b1;
		stall_on = 1'b1;
		for (int i = 0; i < 740; i++) begin
			r = rand_request();
			send_request(r, predict_path(r));
		end

		req_valid <= 1'b0;
		while (path_q.size() != 0)
			@(posedge clk);
		// Waiting on after the drain catches any result the block should not produce.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("[file_block_node_path_mapper] OK");
		else
			$display("[file_block_node_path_mapper] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of about 1100 requests,
	// with stalls, gaps and the long hold-off included.
	initial begin : watchdog
		#(200_000);
		$display("[file_block_node_path_mapper] ERROR");
		$finish;
	end

endmodule
